>>> hdl/coapop_pkg.sv
// Shared types and constants for the CoAP option stream parser.
// No dependencies; imported by coap_option_stream_parser_unit and tb_top.
`timescale 1ns / 1ps

package coapop_pkg;

    // Width of the per-message byte counter
    localparam int MSG_COUNT_BITS = 16;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ROLE_W   = 3;
    localparam int OPT_W    = 20;
    localparam int REG_W    = 16;
    localparam int EXT_W    = 17;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_TDATA_W = 88;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_OPTION  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_MAX_LEN = 1'd1;

    localparam logic [REG_W-1:0] WATCHED_OPTION_RST  = 16'd11;
    localparam logic [REG_W-1:0] WATCHED_MAX_LEN_RST = 16'd255;

    // Byte roles reported on tuser
    localparam logic [ROLE_W-1:0] ROLE_CODE    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_HEADER  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_EXT_DLT = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_EXT_LEN = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_VALUE   = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_MARKER  = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_ERROR   = 3'd7;

    // Parser phases
    localparam logic [3:0] PH_CODE    = 4'd0;
    localparam logic [3:0] PH_HDR     = 4'd1;
    localparam logic [3:0] PH_DHI     = 4'd2;
    localparam logic [3:0] PH_DLO     = 4'd3;
    localparam logic [3:0] PH_LHI     = 4'd4;
    localparam logic [3:0] PH_LLO     = 4'd5;
    localparam logic [3:0] PH_VALUE   = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    // Protocol constants
    localparam logic [BYTE_W-1:0] PAYLOAD_MARK = 8'hFF;
    localparam logic [3:0]        NIB_EXT1     = 4'd13;
    localparam logic [3:0]        NIB_EXT2     = 4'd14;
    localparam logic [3:0]        NIB_BAD      = 4'd15;
    localparam logic [EXT_W-1:0]  EXT2_BASE    = 17'd269;
    localparam logic [OPT_W-1:0]  OPT_SAT      = 20'hFFFFF;
    localparam logic [REG_W-1:0]  LEN_SAT      = 16'hFFFF;

    // One result item, last field (opt_number) in the lowest bits of tdata
    typedef struct packed {
        logic             pad;
        logic [REG_W-1:0] payload_bytes;
        logic [REG_W-1:0] payload_offset;
        logic             payload_found;
        logic [REG_W-1:0] watched_len;
        logic [REG_W-1:0] watched_offset;
        logic             watched_found;
        logic             ok;
        logic [OPT_W-1:0] opt_number;
    } result_t;

endpackage

>>> hdl/coap_option_stream_parser_unit.sv
// CoAP option stream parser: top level with input register, parse logic and result register.
// Depends on coapop_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_tvalid / s_tready        s_tdata = data_byte, s_tlast = last
// m_axis    out        m_tvalid / m_tready        m_tdata = result_t, m_tuser = byte_role,
//                                                 m_tlast = done_res
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// One byte per cycle sustained while m_axis accepts results; a byte goes from the input register into
// the result register when it is parsed, and the parse state is updated once per byte from the input register.
// Reset clears the parse state and loads the register defaults; both stages start empty.
// A stall on m_axis holds the result register and backs up into the input register, which
// keeps taking bytes while the result register is free or draining.

module coap_option_stream_parser_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [coapop_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                   s_tlast,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [19:0] opt_number, [20] ok, [21] watched_found, [37:22] watched_offset,
    // [53:38] watched_len, [54] payload_found, [70:55] payload_offset,
    // [86:71] payload_bytes, [87] zero
    output logic [coapop_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [coapop_pkg::ROLE_W-1:0]          m_tuser,   // [2:0] byte_role
    output logic                                   m_tlast,   // done_res
    // Configuration
    input  logic                                   cfg_we,
    input  logic [coapop_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [coapop_pkg::REG_W-1:0]           cfg_data
);
    import coapop_pkg::*;

    localparam logic [MSG_COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration registers
    logic [REG_W-1:0] watched_option_reg;
    logic [REG_W-1:0] watched_max_len_reg;

    // Input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;

    // Parse state
    logic [3:0]                phase_reg,  phase_next;
    logic [MSG_COUNT_BITS-1:0] cnt_reg,    cnt_next;
    logic [OPT_W-1:0]          opt_reg,    opt_next;
    logic [EXT_W-1:0]          delta_reg,  delta_next;
    logic [EXT_W-1:0]          len_reg,    len_next;
    logic [EXT_W-1:0]          rem_reg,    rem_next;
    logic                      wf_reg,     wf_next;
    logic [REG_W-1:0]          woff_reg,   woff_next;
    logic [REG_W-1:0]          wlen_reg,   wlen_next;
    logic                      pf_reg,     pf_next;
    logic [REG_W-1:0]          poff_reg,   poff_next;
    logic [REG_W-1:0]          plen_reg,   plen_next;

    // Output stage
    logic              out_valid_reg;
    result_t           out_data_reg, out_data_next;
    logic [ROLE_W-1:0] out_role_reg, out_role_next;
    logic              out_last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watched_option_reg  <= WATCHED_OPTION_RST;
            watched_max_len_reg <= WATCHED_MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WATCHED_OPTION:  watched_option_reg  <= cfg_data;
                CFG_WATCHED_MAX_LEN: watched_max_len_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Handshake: parse a held byte when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        logic [3:0]       cur_phase;
        logic [3:0]       dn;
        logic [3:0]       ln;
        logic             good;
        logic             add_req;
        logic [EXT_W-1:0] add_val;
        logic [OPT_W:0]   opt_sum;
        logic             lp_req;
        logic [3:0]       lp_nib;
        logic             fin_req;
        logic [EXT_W-1:0] fin_len;
        logic [EXT_W-1:0] dlo_sum;
        logic [EXT_W-1:0] llo_sum;
        logic [31:0]      cnt_ext;
        logic [REG_W-1:0] next_off;
        logic             hit;
        logic             fine;

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        opt_next   = opt_reg;
        delta_next = delta_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        wf_next    = wf_reg;
        woff_next  = woff_reg;
        wlen_next  = wlen_reg;
        pf_next    = pf_reg;
        poff_next  = poff_reg;
        plen_next  = plen_reg;

        out_role_next = ROLE_ERROR;
        good    = 1'b1;
        add_req = 1'b0;
        add_val = '0;
        lp_req  = 1'b0;
        lp_nib  = '0;
        fin_req = 1'b0;
        fin_len = '0;
        dn      = in_byte_reg[7:4];
        ln      = in_byte_reg[3:0];
        dlo_sum = delta_reg + {{(EXT_W-BYTE_W){1'b0}}, in_byte_reg};
        llo_sum = len_reg + {{(EXT_W-BYTE_W){1'b0}}, in_byte_reg};
        cnt_ext = 32'(cnt_reg);
        next_off = cnt_ext[REG_W-1:0] + 16'd1;

        // Oversize message: the byte at the last count index fails
        cur_phase = phase_reg;
        if (phase_reg != PH_ERROR && cnt_reg == CNT_MAX)
        begin
            cur_phase = PH_ERROR;
        end
        phase_next = cur_phase;

        unique case (cur_phase)
            PH_CODE:
            begin
                out_role_next = ROLE_CODE;
                phase_next    = PH_HDR;
            end
            PH_HDR:
            begin
                if (in_byte_reg == PAYLOAD_MARK)
                begin
                    out_role_next = ROLE_MARKER;
                    pf_next    = 1'b1;
                    poff_next  = next_off;
                    plen_next  = '0;
                    phase_next = PH_PAYLOAD;
                end
                else if (dn == NIB_BAD || ln == NIB_BAD)
                begin
                    good = 1'b0;
                end
                else
                begin
                    out_role_next = ROLE_HEADER;
                    len_next = {{(EXT_W-4){1'b0}}, ln};
                    if (dn == NIB_EXT1)
                    begin
                        delta_next = {{(EXT_W-4){1'b0}}, NIB_EXT1};
                        phase_next = PH_DLO;
                    end
                    else if (dn == NIB_EXT2)
                    begin
                        delta_next = EXT2_BASE;
                        phase_next = PH_DHI;
                    end
                    else
                    begin
                        delta_next = {{(EXT_W-4){1'b0}}, dn};
                        add_req = 1'b1;
                        add_val = {{(EXT_W-4){1'b0}}, dn};
                        lp_req  = 1'b1;
                        lp_nib  = ln;
                    end
                end
            end
            PH_DHI:
            begin
                out_role_next = ROLE_EXT_DLT;
                delta_next = EXT2_BASE + {1'b0, in_byte_reg, 8'd0};
                phase_next = PH_DLO;
            end
            PH_DLO:
            begin
                out_role_next = ROLE_EXT_DLT;
                delta_next = dlo_sum;
                add_req = 1'b1;
                add_val = dlo_sum;
                lp_req  = 1'b1;
                lp_nib  = len_reg[3:0];
            end
            PH_LHI:
            begin
                out_role_next = ROLE_EXT_LEN;
                len_next   = EXT2_BASE + {1'b0, in_byte_reg, 8'd0};
                phase_next = PH_LLO;
            end
            PH_LLO:
            begin
                out_role_next = ROLE_EXT_LEN;
                len_next = llo_sum;
                fin_req  = 1'b1;
                fin_len  = llo_sum;
            end
            PH_VALUE:
            begin
                out_role_next = ROLE_VALUE;
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - 17'd1;
                end
                if (rem_reg <= 17'd1)
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_PAYLOAD:
            begin
                out_role_next = ROLE_PAYLOAD;
                if (plen_reg != LEN_SAT)
                begin
                    plen_next = plen_reg + 16'd1;
                end
            end
            default:
            begin
                out_role_next = ROLE_ERROR;
            end
        endcase

        // Accumulate the option number, saturating
        opt_sum = {1'b0, opt_reg} + {{(OPT_W+1-EXT_W){1'b0}}, add_val};
        if (add_req)
        begin
            opt_next = (opt_sum > {1'b0, OPT_SAT}) ? OPT_SAT : opt_sum[OPT_W-1:0];
        end

        // Length nibble: extend or finish the header
        if (lp_req)
        begin
            len_next = {{(EXT_W-4){1'b0}}, lp_nib};
            if (lp_nib == NIB_EXT1)
            begin
                phase_next = PH_LLO;
            end
            else if (lp_nib == NIB_EXT2)
            begin
                phase_next = PH_LHI;
            end
            else
            begin
                fin_req = 1'b1;
                fin_len = {{(EXT_W-4){1'b0}}, lp_nib};
            end
        end

        // Header complete: check the watched length, record the watched option, enter any value
        hit = (opt_next == {{(OPT_W-REG_W){1'b0}}, watched_option_reg});
        if (fin_req)
        begin
            if (hit && fin_len > {1'b0, watched_max_len_reg})
            begin
                good = 1'b0;
            end
            else
            begin
                if (hit)
                begin
                    wf_next   = 1'b1;
                    woff_next = next_off;
                    wlen_next = fin_len[REG_W-1:0];
                end
                rem_next   = fin_len;
                phase_next = (fin_len != '0) ? PH_VALUE : PH_HDR;
            end
        end

        if (!good)
        begin
            out_role_next = ROLE_ERROR;
            phase_next    = PH_ERROR;
        end

        cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

        // Result fields; summary only on a clean last byte
        fine = phase_next != PH_ERROR && phase_next != PH_DHI && phase_next != PH_DLO &&
               phase_next != PH_LHI && phase_next != PH_LLO && phase_next != PH_VALUE;

        out_data_next = '0;
        out_data_next.opt_number = opt_next;
        if (in_last_reg && fine)
        begin
            out_data_next.ok             = 1'b1;
            out_data_next.watched_found  = wf_next;
            out_data_next.watched_offset = woff_next;
            out_data_next.watched_len    = wlen_next;
            out_data_next.payload_found  = pf_next;
            out_data_next.payload_offset = poff_next;
            out_data_next.payload_bytes  = plen_next;
        end

        // Last byte: start the next message afresh
        if (in_last_reg)
        begin
            phase_next = PH_CODE;
            cnt_next   = '0;
            opt_next   = '0;
            delta_next = '0;
            len_next   = '0;
            rem_next   = '0;
            wf_next    = 1'b0;
            woff_next  = '0;
            wlen_next  = '0;
            pf_next    = 1'b0;
            poff_next  = '0;
            plen_next  = '0;
        end
    end

    // Advance the parse state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            cnt_reg   <= '0;
            opt_reg   <= '0;
            delta_reg <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            wf_reg    <= 1'b0;
            woff_reg  <= '0;
            wlen_reg  <= '0;
            pf_reg    <= 1'b0;
            poff_reg  <= '0;
            plen_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            opt_reg   <= opt_next;
            delta_reg <= delta_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            wf_reg    <= wf_next;
            woff_reg  <= woff_next;
            wlen_reg  <= wlen_next;
            pf_reg    <= pf_next;
            poff_reg  <= poff_next;
            plen_reg  <= plen_next;
        end
    end

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_role_reg <= out_role_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_role_reg;
    assign m_tlast  = out_last_reg;

    // A clean summary only ever comes with the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_data_reg.ok) |-> m_tlast)
        else $error("ok flagged on a byte that does not end the message");

    // An error byte never reports success
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ROLE_ERROR) |-> !out_data_reg.ok)
        else $error("ok flagged on an error byte");

    // The last byte returns the parser to the code byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (phase_reg == PH_CODE && cnt_reg == '0))
        else $error("parse state not cleared after the last byte");

    // A held byte is not lost while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input register dropped a byte during a stall");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for coap_option_stream_parser_unit: drives CoAP message bytes
// on the input stream and checks every per-byte result against a built-in parser model.
// Depends on coapop_pkg and the unit under test; reads no files.
`timescale 1ns / 1ps

module tb_top;

    import coapop_pkg::*;

    localparam int unsigned CNT_MAX   = (1 << MSG_COUNT_BITS) - 1;
    localparam int unsigned LIMIT     = 1_500_000;
    localparam int unsigned MAX_DELTA = 65804;

    // Expected outcome of one input byte
    typedef struct {
        logic [ROLE_W-1:0] role;
        logic              done;
        result_t           res;
    } parse_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;      // [7:0] data_byte
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // result_t, opt_number in the lowest bits
    logic [ROLE_W-1:0]    m_tuser;      // [2:0] byte_role
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    // Parser model state
    logic [REG_W-1:0] reg_watch_opt;
    logic [REG_W-1:0] reg_watch_max;
    logic [3:0]       ph;
    int unsigned      msg_idx;
    logic [OPT_W-1:0] opt_num;
    logic [EXT_W-1:0] delta_acc;
    logic [EXT_W-1:0] len_acc;
    logic [EXT_W-1:0] val_left;
    bit               in_error;
    bit               wf;
    logic [REG_W-1:0] woff;
    logic [REG_W-1:0] wlen;
    bit               pf;
    logic [REG_W-1:0] poff;
    logic [REG_W-1:0] plen;

    parse_out_t        parsed_q[$];
    logic [BYTE_W-1:0] msg[$];
    int unsigned       mismatches;
    int unsigned       bytes_sent;
    int unsigned       cycles;
    int unsigned       hold_cycles;
    bit                idling;

    coap_option_stream_parser_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("coap_option_stream_parser_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- parser model

    function automatic void clear_msg();
        ph        = PH_CODE;
        msg_idx   = 0;
        opt_num   = '0;
        delta_acc = '0;
        len_acc   = '0;
        val_left  = '0;
        in_error  = 1'b0;
        wf        = 1'b0;
        woff      = '0;
        wlen      = '0;
        pf        = 1'b0;
        poff      = '0;
        plen      = '0;
    endfunction

    // Add a delta to the running option number, saturating
    function automatic void add_delta(input logic [EXT_W-1:0] d);
        int unsigned s;
        s = opt_num + d;
        opt_num = (s > OPT_SAT) ? OPT_SAT : s[OPT_W-1:0];
    endfunction

    // Length known: note the watched option, arm the value skip; 0 if the value is too long
    function automatic bit hdr_done(input logic [EXT_W-1:0] vlen);
        if (opt_num == {4'b0, reg_watch_opt})
        begin
            if (vlen > reg_watch_max)
                return 1'b0;
            wf   = 1'b1;
            woff = 16'(msg_idx + 1);
            wlen = vlen[REG_W-1:0];
        end
        val_left = vlen;
        ph = (vlen != 0) ? PH_VALUE : PH_HDR;
        return 1'b1;
    endfunction

    function automatic bit len_step(input logic [3:0] ln);
        len_acc = EXT_W'(ln);
        if (ln == NIB_EXT1)
        begin
            ph = PH_LLO;
            return 1'b1;
        end
        if (ln == NIB_EXT2)
        begin
            ph = PH_LHI;
            return 1'b1;
        end
        return hdr_done(EXT_W'(ln));
    endfunction

    // Work out the result of one accepted byte and queue it
    function automatic void parse_byte(input logic [BYTE_W-1:0] b, input logic lst);
        parse_out_t        e;
        logic [ROLE_W-1:0] role;
        bit                good;
        role = ROLE_ERROR;
        good = 1'b1;
        if (!in_error && msg_idx >= CNT_MAX)
        begin
            in_error = 1'b1;
            ph = PH_ERROR;
        end
        case (ph)
            PH_CODE:
            begin
                role = ROLE_CODE;
                ph = PH_HDR;
            end
            PH_HDR:
            begin
                if (b == PAYLOAD_MARK)
                begin
                    role = ROLE_MARKER;
                    pf   = 1'b1;
                    poff = 16'(msg_idx + 1);
                    plen = '0;
                    ph   = PH_PAYLOAD;
                end
                else if (b[7:4] == NIB_BAD || b[3:0] == NIB_BAD)
                    good = 1'b0;
                else
                begin
                    role = ROLE_HEADER;
                    len_acc = EXT_W'(b[3:0]);
                    if (b[7:4] == NIB_EXT1)
                    begin
                        delta_acc = EXT_W'(NIB_EXT1);
                        ph = PH_DLO;
                    end
                    else if (b[7:4] == NIB_EXT2)
                    begin
                        delta_acc = EXT2_BASE;
                        ph = PH_DHI;
                    end
                    else
                    begin
                        delta_acc = EXT_W'(b[7:4]);
                        add_delta(delta_acc);
                        good = len_step(b[3:0]);
                    end
                end
            end
            PH_DHI:
            begin
                role = ROLE_EXT_DLT;
                delta_acc = EXT2_BASE + {1'b0, b, 8'h00};
                ph = PH_DLO;
            end
            PH_DLO:
            begin
                role = ROLE_EXT_DLT;
                delta_acc = delta_acc + b;
                add_delta(delta_acc);
                good = len_step(len_acc[3:0]);
            end
            PH_LHI:
            begin
                role = ROLE_EXT_LEN;
                len_acc = EXT2_BASE + {1'b0, b, 8'h00};
                ph = PH_LLO;
            end
            PH_LLO:
            begin
                role = ROLE_EXT_LEN;
                len_acc = len_acc + b;
                good = hdr_done(len_acc);
            end
            PH_VALUE:
            begin
                role = ROLE_VALUE;
                if (val_left > 0)
                    val_left = val_left - 1'b1;
                if (val_left == 0)
                    ph = PH_HDR;
            end
            PH_PAYLOAD:
            begin
                role = ROLE_PAYLOAD;
                if (plen < LEN_SAT)
                    plen = plen + 1'b1;
            end
            default:
                role = ROLE_ERROR;
        endcase
        if (!good)
        begin
            role = ROLE_ERROR;
            in_error = 1'b1;
            ph = PH_ERROR;
        end
        if (msg_idx < CNT_MAX)
            msg_idx++;

        e.role = role;
        e.done = lst;
        e.res  = '0;
        e.res.opt_number = opt_num;
        if (lst)
        begin
            // Summary only for a clean message that ended between options or in the payload
            if (!in_error && !(ph inside {PH_DHI, PH_DLO, PH_LHI, PH_LLO, PH_VALUE}))
            begin
                e.res.ok             = 1'b1;
                e.res.watched_found  = wf;
                e.res.watched_offset = woff;
                e.res.watched_len    = wlen;
                e.res.payload_found  = pf;
                e.res.payload_offset = poff;
                e.res.payload_bytes  = plen;
            end
            clear_msg();
        end
        parsed_q.push_back(e);
    endfunction

    // ---------------------------------------------------------------- result checking

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned seen);
        if (want != seen)
        begin
            if (mismatches < 50)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        parse_out_t e;
        result_t    got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (parsed_q.size() == 0)
            begin
                if (mismatches < 50)
                    $display("%0t ns: result expected none, got role %0d data %h",
                             $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                e = parsed_q.pop_front();
                check_field("byte_role", e.role, m_tuser);
                check_field("done_res", e.done, m_tlast);
                check_field("opt_number", e.res.opt_number, got.opt_number);
                check_field("ok", e.res.ok, got.ok);
                check_field("watched_found", e.res.watched_found, got.watched_found);
                check_field("watched_offset", e.res.watched_offset, got.watched_offset);
                check_field("watched_len", e.res.watched_len, got.watched_len);
                check_field("payload_found", e.res.payload_found, got.payload_found);
                check_field("payload_offset", e.res.payload_offset, got.payload_offset);
                check_field("payload_bytes", e.res.payload_bytes, got.payload_bytes);
                check_field("pad", 0, got.pad);
            end
        end
    end

    // Result side: random stall bursts, plus a long hold-off on request
    initial
    begin : result_ready
        int unsigned stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    // Offer one byte, with an occasional gap first; predict it once the transfer happens
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
        int unsigned gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        parse_byte(b, lst);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_msg();
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Stop offering and hold until every expected result has been seen
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (parsed_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WATCHED_OPTION)
            reg_watch_opt = val;
        else
            reg_watch_max = val;
        @(negedge clk);
    endtask

    function automatic logic [3:0] nib_of(input int unsigned v);
        if (v < 13)
            return 4'(v);
        return (v < 269) ? NIB_EXT1 : NIB_EXT2;
    endfunction

    function automatic void push_ext(input int unsigned v);
        if (v >= 269)
        begin
            msg.push_back(8'((v - 269) >> 8));
            msg.push_back(8'(v - 269));
        end
        else if (v >= 13)
            msg.push_back(8'(v - 13));
    endfunction

    function automatic void begin_msg(input logic [BYTE_W-1:0] code);
        msg.delete();
        msg.push_back(code);
    endfunction

    // Option header with its extension bytes; value bytes are added separately
    function automatic void put_option(input int unsigned delta, input int unsigned vlen);
        msg.push_back({nib_of(delta), nib_of(vlen)});
        push_ext(delta);
        push_ext(vlen);
    endfunction

    function automatic void put_value(input int unsigned n);
        repeat (n) msg.push_back(8'($urandom));
    endfunction

    // Mostly well-formed messages with random content; some noise, truncation, bad nibbles
    function automatic void build_random_msg();
        int unsigned run;
        int unsigned d;
        int unsigned l;
        int unsigned n;
        int unsigned kind;
        int unsigned cut;
        logic [3:0]  nib;
        begin_msg(8'($urandom));
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            put_value($urandom_range(0, 8));
            return;
        end
        run = 0;
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: d = $urandom_range(13, 268);
                3:       d = $urandom_range(269, MAX_DELTA);
                4, 5, 6, 7, 8:
                    d = (reg_watch_opt >= run && reg_watch_opt - run <= MAX_DELTA) ?
                        reg_watch_opt - run : $urandom_range(0, 12);
                default: d = $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 39))
                0:          l = $urandom_range(269, 272);
                1, 2, 3, 4: l = $urandom_range(13, 40);
                default:    l = $urandom_range(0, 12);
            endcase
            put_option(d, l);
            put_value(l);
            run += d;
        end
        if (kind == 2)
        begin
            // Header with a reserved nibble, then trailing junk
            nib = 4'($urandom_range(0, 14));
            msg.push_back($urandom_range(0, 1) ? {NIB_BAD, nib} : {nib, NIB_BAD});
            put_value($urandom_range(0, 3));
            return;
        end
        if ($urandom_range(0, 1))
        begin
            msg.push_back(PAYLOAD_MARK);
            put_value($urandom_range(0, 10));
        end
        if (kind == 3 || kind == 4)
        begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
    endfunction

    function automatic logic [REG_W-1:0] pick_watch();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd11;
            2:       return 16'hFFFF;
            3:       return 16'd1;
            4:       return 16'd60;
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_max();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd3;
            2:       return 16'd12;
            3:       return 16'd255;
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // Hand-built messages covering each byte role and the corner cases, default registers
    task automatic test_directed();
        // code byte alone
        begin_msg(8'h40);
        send_msg();
        // watched option with extreme value bytes, then a two byte payload
        begin_msg(8'h45);
        put_option(11, 3);
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        msg.push_back(8'h5A);
        msg.push_back(PAYLOAD_MARK);
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        send_msg();
        // marker on the last byte: empty payload
        begin_msg(8'hFF);
        msg.push_back(PAYLOAD_MARK);
        send_msg();
        // reserved nibble in delta, then in length on the last byte
        begin_msg(8'h00);
        msg.push_back(8'hF1);
        msg.push_back(8'h22);
        send_msg();
        begin_msg(8'h01);
        msg.push_back(8'h1F);
        send_msg();
        // one byte extensions on both nibbles and a two byte delta extension
        begin_msg(8'h02);
        put_option(13, 1);
        put_value(1);
        put_option(270, 14);
        put_value(14);
        put_option(0, 0);
        send_msg();
        // watched option repeated: the later one is kept
        begin_msg(8'h03);
        put_option(11, 2);
        put_value(2);
        put_option(0, 1);
        put_value(1);
        send_msg();
        // end inside a delta extension, then inside a value
        begin_msg(8'h04);
        msg.push_back(8'hE0);
        msg.push_back(8'h01);
        send_msg();
        begin_msg(8'h05);
        put_option(3, 4);
        put_value(2);
        send_msg();
        // watched value over the limit
        begin_msg(8'h06);
        put_option(11, 300);
        put_value(2);
        send_msg();
        // option number saturates
        begin_msg(8'h07);
        repeat (16) put_option(MAX_DELTA, 0);
        send_msg();
        wait_drain();
    endtask

    // Register extremes: watched option 0 and 65535, length limit 0 and 65535; then limit 2 on option 11
    task automatic test_config();
        cfg_write(CFG_WATCHED_OPTION, 16'd0);
        cfg_write(CFG_WATCHED_MAX_LEN, 16'd0);
        begin_msg(8'h10);
        put_option(0, 0);
        put_option(5, 1);
        put_value(1);
        send_msg();
        begin_msg(8'h11);
        put_option(0, 1);
        put_value(1);
        send_msg();
        wait_drain();

        cfg_write(CFG_WATCHED_OPTION, 16'hFFFF);
        cfg_write(CFG_WATCHED_MAX_LEN, 16'hFFFF);
        begin_msg(8'h12);
        put_option(65535, 2);
        put_value(2);
        msg.push_back(PAYLOAD_MARK);
        put_value(3);
        send_msg();
        // longest allowed length, cut short after the header
        begin_msg(8'h13);
        put_option(65535, 65535);
        send_msg();
        // one past the limit
        begin_msg(8'h14);
        put_option(65535, 65536);
        put_value(1);
        send_msg();
        wait_drain();

        cfg_write(CFG_WATCHED_OPTION, WATCHED_OPTION_RST);
        cfg_write(CFG_WATCHED_MAX_LEN, 16'd2);
        begin_msg(8'h15);
        put_option(11, 2);
        put_value(2);
        put_option(0, 3);
        put_value(3);
        send_msg();
        wait_drain();
    endtask

    // Long result hold-off while the sender keeps offering, then a sender pause
    task automatic test_backpressure();
        idling = 1'b0;
        begin_msg(8'h20);
        put_option(11, 5);
        put_value(5);
        msg.push_back(PAYLOAD_MARK);
        put_value(60);
        hold_cycles = 300;
        send_msg();
        wait_drain();
        build_random_msg();
        send_msg();
        wait_drain();
        idling = 1'b1;
    endtask

    task automatic test_random();
        int unsigned target;
        int unsigned nmsg;
        target = bytes_sent + 1500;
        nmsg = 0;
        idling = 1'b1;
        while (bytes_sent < target)
        begin
            // Move to a new register setting every few dozen messages
            if (nmsg % 40 == 0)
            begin
                wait_drain();
                cfg_write(CFG_WATCHED_OPTION, pick_watch());
                cfg_write(CFG_WATCHED_MAX_LEN, pick_max());
            end
            if (bytes_sent + 300 >= target)
                idling = 1'b0;
            build_random_msg();
            send_msg();
            nmsg++;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        bytes_sent  = 0;
        cycles      = 0;
        hold_cycles = 0;
        idling      = 1'b1;
        reg_watch_opt = WATCHED_OPTION_RST;
        reg_watch_max = WATCHED_MAX_LEN_RST;
        clear_msg();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_config();
        test_backpressure();
        test_random();

        // Let the pipeline settle after the last result
        wait_drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && parsed_q.size() == 0)
            $display("coap_option_stream_parser_unit verification clean");
        else
            $display("coap_option_stream_parser_unit verification failed");
        $finish;
    end

endmodule
